// ----- src/quadratic_stencil_field_interp_unit_defines.svh -----
// Assertion macros shared by the checker of the stencil interpolation unit.
`ifndef QUADRATIC_STENCIL_FIELD_INTERP_UNIT_DEFINES_SVH
`define QUADRATIC_STENCIL_FIELD_INTERP_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define QSFI_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("qsfi checker: same-cycle rule violated");

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define QSFI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("qsfi checker: next-cycle rule violated");

// Next-cycle implication that is also checked while reset is applied.
`define QSFI_ASSERT_RESET_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("qsfi checker: reset rule violated");

`endif

// ----- src/qsfi_pkg.sv -----
// Package of the stencil interpolation unit: widths, types, constants and helpers.
`default_nettype none

package qsfi_pkg;

  localparam int SAMPLE_BITS      = 24;
  localparam int OFFSET_FRAC_BITS = 14;
  localparam int OFFSET_BITS      = OFFSET_FRAC_BITS + 2;

  localparam int NUM_AXES   = 3;
  localparam int NUM_COEFS  = 7;
  localparam int PIPE_DEPTH = 8;

  // Coefficient slots.
  localparam int COEF_MEAN = 0;
  localparam int COEF_GRAD = 1;
  localparam int COEF_CURV = COEF_GRAD + NUM_AXES;

  // Intermediate widths.
  localparam int DIV_W    = SAMPLE_BITS + 4;
  localparam int FIRST_W  = SAMPLE_BITS + 1;
  localparam int SECOND_W = SAMPLE_BITS + 2;
  localparam int FD_W     = FIRST_W + OFFSET_BITS;
  localparam int DD_W     = 2 * OFFSET_BITS;
  localparam int SDD_W    = SECOND_W + DD_W;
  localparam int ACC_SH   = 2 * OFFSET_FRAC_BITS;
  localparam int ACC_W    = SAMPLE_BITS + ACC_SH + 7;
  localparam int LOW_W    = ACC_W - ACC_SH;
  localparam int FD_SHIFT = OFFSET_FRAC_BITS + 1;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [OFFSET_BITS-1:0] offset_t;
  typedef logic signed [DIV_W-1:0]       div_t;
  typedef logic signed [FIRST_W-1:0]     first_t;
  typedef logic signed [SECOND_W-1:0]    second_t;
  typedef logic signed [FD_W-1:0]        fd_t;
  typedef logic signed [DD_W-1:0]        dd_t;
  typedef logic signed [SDD_W-1:0]       sdd_t;
  typedef logic signed [ACC_W-1:0]       acc_t;
  typedef logic signed [LOW_W-1:0]       low_t;

  typedef enum logic {
    MODE_NGP  = 1'b0,
    MODE_QUAD = 1'b1
  } interp_mode_t;

  // Rounding biases: half of the divisor.
  localparam int BIAS_DIV12 = 6;
  localparam int BIAS_DIV6  = 3;

  // Half an output LSB in accumulator units, and the accumulator range that
  // still divides by twelve into the sample range.
  localparam acc_t ACC_HALF = acc_t'(BIAS_DIV12) <<< ACC_SH;
  localparam low_t LOW_MIN  = -(low_t'(12) <<< (SAMPLE_BITS - 1));
  localparam low_t LOW_MAX  = (low_t'(12) <<< (SAMPLE_BITS - 1)) - low_t'(1);

  // Floor division by three: offset to a positive value, then multiply by a
  // rounded-up reciprocal and drop the low bits.
  localparam int DIV_U_W = DIV_W + 1;
  localparam int DIV_M_W = DIV_W + 2;
  localparam int DIV_SH  = DIV_W + 3;
  localparam int DIV_P_W = DIV_U_W + DIV_M_W;

  typedef logic [DIV_U_W-1:0] div_u_t;
  typedef logic [DIV_P_W-1:0] div_p_t;

  localparam logic [DIV_M_W-1:0] DIV3_MUL =
      DIV_M_W'(((64'd1 << DIV_SH) + 64'd2) / 64'd3);
  localparam div_u_t DIV3_OFS  = DIV_U_W'(64'd3 << (DIV_W - 2));
  localparam div_t   DIV3_QOFS = div_t'(64'd1 << (DIV_W - 2));

  function automatic div_u_t div3_pre(input div_t x);
    return div_u_t'(DIV_U_W'(x)) + DIV3_OFS;
  endfunction

  function automatic div_t div3_post(input div_p_t p);
    return div_t'(p[DIV_SH +: DIV_W]) - DIV3_QOFS;
  endfunction

  // Dividend for a rounded division by twelve, pre-scaled so that only a
  // floor division by three remains.
  function automatic div_t arg_div12(input div_t v);
    logic signed [DIV_W:0] t;
    t = (DIV_W + 1)'(v) + (DIV_W + 1)'(BIAS_DIV12);
    return div_t'(t >>> 2);
  endfunction

  // Same for a rounded division by six.
  function automatic div_t arg_div6(input div_t v);
    logic signed [DIV_W:0] t;
    t = (DIV_W + 1)'(v) + (DIV_W + 1)'(BIAS_DIV6);
    return div_t'(t >>> 1);
  endfunction

endpackage

`default_nettype wire

// ----- src/qsfi_in_if.sv -----
// Input channel of the stencil interpolation unit: stencil samples and offset.
`default_nettype none

interface qsfi_in_if
  import qsfi_pkg::*;
();

  logic    valid;
  logic    ready;
  sample_t center_value;
  sample_t plus_x_value;
  sample_t plus_y_value;
  sample_t plus_z_value;
  sample_t minus_x_value;
  sample_t minus_y_value;
  sample_t minus_z_value;
  offset_t offset_x;
  offset_t offset_y;
  offset_t offset_z;

  modport source (
    output valid, center_value, plus_x_value, plus_y_value, plus_z_value,
           minus_x_value, minus_y_value, minus_z_value,
           offset_x, offset_y, offset_z,
    input  ready
  );

  modport sink (
    input  valid, center_value, plus_x_value, plus_y_value, plus_z_value,
           minus_x_value, minus_y_value, minus_z_value,
           offset_x, offset_y, offset_z,
    output ready
  );

endinterface

`default_nettype wire

// ----- src/qsfi_out_if.sv -----
// Result channel of the stencil interpolation unit: coefficients and value.
`default_nettype none

interface qsfi_out_if
  import qsfi_pkg::*;
();

  logic    valid;
  logic    ready;
  sample_t mean_coef;
  sample_t grad_x_coef;
  sample_t grad_y_coef;
  sample_t grad_z_coef;
  sample_t curv_x_coef;
  sample_t curv_y_coef;
  sample_t curv_z_coef;
  sample_t field_at_offset;

  modport source (
    output valid, mean_coef, grad_x_coef, grad_y_coef, grad_z_coef,
           curv_x_coef, curv_y_coef, curv_z_coef, field_at_offset,
    input  ready
  );

  modport sink (
    input  valid, mean_coef, grad_x_coef, grad_y_coef, grad_z_coef,
           curv_x_coef, curv_y_coef, curv_z_coef, field_at_offset,
    output ready
  );

endinterface

`default_nettype wire

// ----- src/quadratic_stencil_field_interp_unit.sv -----
// Top level of the quadratic seven-point stencil field interpolation unit.
`default_nettype none

// Quadratic stencil field interpolation. Each input word carries a field
// sample at a cell center, its six face neighbors and a particle offset in
// Q2.14 per axis. The unit returns one result word per input word: the
// smoothed mean (6*c + neighbors)/12, the three central differences (p-m)/6,
// the three second differences (p+m-2c)/12, and the field at the offset,
// mean + sum of d*(first + d*second), evaluated exactly and rounded once.
// All divisions round to nearest with ties toward plus infinity, and the
// field value saturates to the signed sample range. With interp_mode at 0
// (nearest grid point) the mean and the field value are the center sample
// and the six difference coefficients are zero; reset selects the quadratic
// stencil. The unit is an eight-stage pipeline: it takes one word per clock
// while the result side does not stall. The depth is set by the multiply
// chain of the value path (offset squared, times the second difference,
// accumulate, then a divide by twelve done as a multiply by a reciprocal).
// All stages share one advance enable, which is high whenever the result
// register is empty or being taken; in_chan.ready is that enable, so a stall
// freezes every stage and no word is dropped or repeated. interp_mode is
// written through cfg_wr_en and cfg_wr_data; the user must write it only
// while the pipeline is empty, which the unit does not enforce. It is
// sampled by each word as it enters.

module quadratic_stencil_field_interp_unit
  import qsfi_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   cfg_wr_en,
  input  wire logic   cfg_wr_data,
  qsfi_in_if.sink     in_chan,
  qsfi_out_if.source  out_chan
);

  // Configuration register.
  interp_mode_t mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_QUAD;
    end else if (cfg_wr_en) begin
      mode_r <= interp_mode_t'(cfg_wr_data);
    end
  end

  // Pipeline advance: move whenever the output register is free or taken.
  logic                  en;
  logic [PIPE_DEPTH-1:0] vld_r;
  logic [PIPE_DEPTH-1:0] vld_nxt;

  assign en = !vld_r[PIPE_DEPTH-1] || out_chan.ready;

  always_comb begin
    vld_nxt = {vld_r[PIPE_DEPTH-2:0], in_chan.valid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  // Stage 1: smoothed sum, first and second differences per axis.
  sample_t      p_in [NUM_AXES];
  sample_t      m_in [NUM_AXES];
  offset_t      d_in [NUM_AXES];
  div_t         smooth_nxt;
  first_t       first_nxt [NUM_AXES];
  second_t      second_nxt [NUM_AXES];

  interp_mode_t mode_s1_r;
  sample_t      c_s1_r;
  div_t         smooth_s1_r;
  first_t       first_s1_r [NUM_AXES];
  second_t      second_s1_r [NUM_AXES];
  offset_t      d_s1_r [NUM_AXES];

  always_comb begin
    p_in[0] = in_chan.plus_x_value;
    p_in[1] = in_chan.plus_y_value;
    p_in[2] = in_chan.plus_z_value;
    m_in[0] = in_chan.minus_x_value;
    m_in[1] = in_chan.minus_y_value;
    m_in[2] = in_chan.minus_z_value;
    d_in[0] = in_chan.offset_x;
    d_in[1] = in_chan.offset_y;
    d_in[2] = in_chan.offset_z;

    // Six times the center as a four-plus-two shift pair.
    smooth_nxt = (div_t'(in_chan.center_value) <<< 2)
               + (div_t'(in_chan.center_value) <<< 1);
    for (int i = 0; i < NUM_AXES; i++) begin
      smooth_nxt    = smooth_nxt + div_t'(p_in[i]) + div_t'(m_in[i]);
      first_nxt[i]  = first_t'(p_in[i]) - first_t'(m_in[i]);
      second_nxt[i] = second_t'(p_in[i]) + second_t'(m_in[i])
                    - (second_t'(in_chan.center_value) <<< 1);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mode_s1_r   <= mode_r;
      c_s1_r      <= in_chan.center_value;
      smooth_s1_r <= smooth_nxt;
      for (int i = 0; i < NUM_AXES; i++) begin
        first_s1_r[i]  <= first_nxt[i];
        second_s1_r[i] <= second_nxt[i];
        d_s1_r[i]      <= d_in[i];
      end
    end
  end

  // Coefficient dividers: each result is a floor division by three of a
  // pre-biased, pre-shifted sum or difference. They take stage 1 and deliver
  // alongside stage 3.
  div_t coef_arg [NUM_COEFS];
  div_t coef_q [NUM_COEFS];

  always_comb begin
    coef_arg[COEF_MEAN] = arg_div12(smooth_s1_r);
    for (int i = 0; i < NUM_AXES; i++) begin
      coef_arg[COEF_GRAD + i] = arg_div6(div_t'(first_s1_r[i]));
      coef_arg[COEF_CURV + i] = arg_div12(div_t'(second_s1_r[i]));
    end
  end

  for (genvar k = 0; k < NUM_COEFS; k++) begin : g_coef_div
    qsfi_div3 u_div (
      .clk (clk),
      .en  (en),
      .x   (coef_arg[k]),
      .q   (coef_q[k])
    );
  end

  // Stage 2: offset squared and first difference times offset.
  interp_mode_t mode_s2_r;
  sample_t      c_s2_r;
  div_t         smooth_s2_r;
  fd_t          fd_s2_r [NUM_AXES];
  dd_t          dd_s2_r [NUM_AXES];
  second_t      second_s2_r [NUM_AXES];

  always_ff @(posedge clk) begin
    if (en) begin
      mode_s2_r   <= mode_s1_r;
      c_s2_r      <= c_s1_r;
      smooth_s2_r <= smooth_s1_r;
      for (int i = 0; i < NUM_AXES; i++) begin
        fd_s2_r[i]     <= fd_t'(first_s1_r[i]) * fd_t'(d_s1_r[i]);
        dd_s2_r[i]     <= dd_t'(d_s1_r[i]) * dd_t'(d_s1_r[i]);
        second_s2_r[i] <= second_s1_r[i];
      end
    end
  end

  // Stage 3: second difference times offset squared.
  interp_mode_t mode_s3_r;
  sample_t      c_s3_r;
  div_t         smooth_s3_r;
  fd_t          fd_s3_r [NUM_AXES];
  sdd_t         sdd_s3_r [NUM_AXES];

  always_ff @(posedge clk) begin
    if (en) begin
      mode_s3_r   <= mode_s2_r;
      c_s3_r      <= c_s2_r;
      smooth_s3_r <= smooth_s2_r;
      for (int i = 0; i < NUM_AXES; i++) begin
        fd_s3_r[i]  <= fd_s2_r[i];
        sdd_s3_r[i] <= sdd_t'(second_s2_r[i]) * sdd_t'(dd_s2_r[i]);
      end
    end
  end

  // Stage 4: two partial sums of the value, scaled by twelve times 2^(2F),
  // and the coefficients with the nearest grid point override applied.
  acc_t         sum_a_nxt;
  acc_t         sum_b_nxt;
  sample_t      coef_s4_nxt [NUM_COEFS];

  interp_mode_t mode_s4_r;
  sample_t      c_s4_r;
  acc_t         sum_a_s4_r;
  acc_t         sum_b_s4_r;
  sample_t      coef_s4_r [NUM_COEFS];

  always_comb begin
    sum_a_nxt = (acc_t'(smooth_s3_r) <<< ACC_SH) + ACC_HALF
              + (acc_t'(fd_s3_r[0]) <<< FD_SHIFT)
              + (acc_t'(fd_s3_r[1]) <<< FD_SHIFT);
    sum_b_nxt = (acc_t'(fd_s3_r[2]) <<< FD_SHIFT)
              + acc_t'(sdd_s3_r[0]) + acc_t'(sdd_s3_r[1]) + acc_t'(sdd_s3_r[2]);
    for (int k = 0; k < NUM_COEFS; k++) begin
      if (mode_s3_r == MODE_QUAD) begin
        coef_s4_nxt[k] = sample_t'(coef_q[k]);
      end else if (k == COEF_MEAN) begin
        coef_s4_nxt[k] = c_s3_r;
      end else begin
        coef_s4_nxt[k] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mode_s4_r  <= mode_s3_r;
      c_s4_r     <= c_s3_r;
      sum_a_s4_r <= sum_a_nxt;
      sum_b_s4_r <= sum_b_nxt;
      for (int k = 0; k < NUM_COEFS; k++) begin
        coef_s4_r[k] <= coef_s4_nxt[k];
      end
    end
  end

  // Stage 5: full accumulator.
  interp_mode_t mode_s5_r;
  sample_t      c_s5_r;
  acc_t         acc_s5_r;
  sample_t      coef_s5_r [NUM_COEFS];

  always_ff @(posedge clk) begin
    if (en) begin
      mode_s5_r <= mode_s4_r;
      c_s5_r    <= c_s4_r;
      acc_s5_r  <= sum_a_s4_r + sum_b_s4_r;
      for (int k = 0; k < NUM_COEFS; k++) begin
        coef_s5_r[k] <= coef_s4_r[k];
      end
    end
  end

  // Stage 6: drop the fraction, clamp to the range that divides into the
  // sample range, and pre-shift for the divide by three. In nearest grid
  // point mode three times the center is fed instead, so the divider
  // returns the center unchanged.
  low_t low_val;
  low_t low_clamped;
  div_t x_s6_nxt;

  div_t    x_s6_r;
  sample_t coef_s6_r [NUM_COEFS];

  always_comb begin
    low_val = acc_s5_r[ACC_W-1:ACC_SH];
    if (low_val < LOW_MIN) begin
      low_clamped = LOW_MIN;
    end else if (low_val > LOW_MAX) begin
      low_clamped = LOW_MAX;
    end else begin
      low_clamped = low_val;
    end
    if (mode_s5_r == MODE_QUAD) begin
      x_s6_nxt = div_t'(low_clamped >>> 2);
    end else begin
      x_s6_nxt = (div_t'(c_s5_r) <<< 1) + div_t'(c_s5_r);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_s6_r <= x_s6_nxt;
      for (int k = 0; k < NUM_COEFS; k++) begin
        coef_s6_r[k] <= coef_s5_r[k];
      end
    end
  end

  // Stages 7 and 8: final divide by three; its output register is the
  // value field of the result register.
  div_t    field_q;
  sample_t coef_s7_r [NUM_COEFS];
  sample_t coef_s8_r [NUM_COEFS];

  qsfi_div3 u_field_div (
    .clk (clk),
    .en  (en),
    .x   (x_s6_r),
    .q   (field_q)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NUM_COEFS; k++) begin
        coef_s7_r[k] <= coef_s6_r[k];
        coef_s8_r[k] <= coef_s7_r[k];
      end
    end
  end

  // Channel outputs.
  assign in_chan.ready            = en;
  assign out_chan.valid           = vld_r[PIPE_DEPTH-1];
  assign out_chan.mean_coef       = coef_s8_r[COEF_MEAN];
  assign out_chan.grad_x_coef     = coef_s8_r[COEF_GRAD];
  assign out_chan.grad_y_coef     = coef_s8_r[COEF_GRAD + 1];
  assign out_chan.grad_z_coef     = coef_s8_r[COEF_GRAD + 2];
  assign out_chan.curv_x_coef     = coef_s8_r[COEF_CURV];
  assign out_chan.curv_y_coef     = coef_s8_r[COEF_CURV + 1];
  assign out_chan.curv_z_coef     = coef_s8_r[COEF_CURV + 2];
  assign out_chan.field_at_offset = sample_t'(field_q);

endmodule

`default_nettype wire

// ----- src/qsfi_div3.sv -----
// Two-stage floor division by three of a signed value, stalled by an enable.
`default_nettype none

module qsfi_div3
  import qsfi_pkg::*;
(
  input  wire logic clk,
  input  wire logic en,
  input  wire div_t x,
  output div_t      q
);

  div_p_t prod_r;
  div_p_t prod_nxt;
  div_t   q_r;
  div_t   q_nxt;

  always_comb begin
    prod_nxt = div_p_t'(div3_pre(x)) * div_p_t'(DIV3_MUL);
    q_nxt    = div3_post(prod_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
      q_r    <= q_nxt;
    end
  end

  assign q = q_r;

endmodule

`default_nettype wire

// ----- src/qsfi_checker.sv -----
// Port-level checker of the stencil interpolation unit and its bind.
`default_nettype none

`include "quadratic_stencil_field_interp_unit_defines.svh"

module qsfi_checker
  import qsfi_pkg::*;
(
  input wire logic    clk,
  input wire logic    rst_n,
  input wire logic    in_ready,
  input wire logic    out_valid,
  input wire logic    out_ready,
  input wire sample_t out_mean,
  input wire sample_t out_field
);

  // Taking a result word always lets a new input word in.
  `QSFI_ASSERT_IMPLY(a_take_frees_input, out_ready, in_ready)

  // A stalled result word stays put with its payload.
  `QSFI_ASSERT_NEXT(a_stall_holds, out_valid && !out_ready, out_valid && $stable(out_mean) && $stable(out_field))

  // Reset empties the pipeline by the next cycle.
  `QSFI_ASSERT_RESET_NEXT(a_reset_empties, !rst_n, !out_valid)

endmodule

bind quadratic_stencil_field_interp_unit qsfi_checker u_qsfi_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_mean  (out_chan.mean_coef),
  .out_field (out_chan.field_at_offset)
);

`default_nettype wire
